// ===== design/lrkc_pkg.sv =====
// Package for the LFU recent-key cache: sizes, codes and the structs
// passed between the top level, the cell chain and the cells. No dependencies.
`timescale 1ns / 1ps

package lrkc_pkg;

  localparam int SLOTS      = 16;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 31;
  localparam int HANDLE_W   = 32;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Operation codes carried by the operation field
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_code_t;

  // Kinds of slot update broadcast after a scan
  typedef enum logic [1:0] {
    UPD_BUMP  = 2'd0,
    UPD_FILL  = 2'd1,
    UPD_CLEAR = 2'd2
  } upd_kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_UPDATE = 2'd2
  } ctrl_state_t;

  // Search token that walks down the chain, one cell per cycle
  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      hit_idx;
    logic [HANDLE_W-1:0]   hit_handle;
    logic [COUNT_BITS-1:0] least_count;
    logic [IDX_W-1:0]      min_idx;
  } scan_t;

  // Slot update command, seen by all cells, taken by the addressed one
  typedef struct packed {
    logic                en;
    upd_kind_t           kind;
    logic [IDX_W-1:0]    idx;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } upd_t;

endpackage

// ===== design/lrkc_cell.sv =====
// One cache slot: valid, key, handle and use count, plus one stage of the
// search token pipeline. Depends on lrkc_pkg.
`timescale 1ns / 1ps

module lrkc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lrkc_pkg::IDX_W-1:0]    cell_idx,
  input  logic [lrkc_pkg::KEY_W-1:0]    req_key,
  input  logic                          scan_in_valid,
  input  lrkc_pkg::scan_t               scan_in,
  output logic                          scan_out_valid,
  output lrkc_pkg::scan_t               scan_out,
  input  lrkc_pkg::upd_t                upd
);
  import lrkc_pkg::*;

  logic                  valid;
  logic [KEY_W-1:0]      key;
  logic [HANDLE_W-1:0]   handle;
  logic [COUNT_BITS-1:0] count;

  logic  match;
  scan_t scan_next;
  logic  sel;

  // Merge this slot into the token: first match wins, strict-less minimum
  always_comb begin
    match     = valid && (key == req_key);
    scan_next = scan_in;
    if (match && !scan_in.found) begin
      scan_next.found      = 1'b1;
      scan_next.hit_idx    = cell_idx;
      scan_next.hit_handle = handle;
    end
    if (count < scan_in.least_count) begin
      scan_next.least_count = count;
      scan_next.min_idx     = cell_idx;
    end
  end

  // Token stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out_valid <= 1'b0;
    end else begin
      scan_out_valid <= scan_in_valid;
    end
    if (scan_in_valid) begin
      scan_out <= scan_next;
    end
  end

  assign sel = upd.en && (upd.idx == cell_idx);

  // Slot contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      key    <= '0;
      handle <= '0;
      count  <= '0;
    end else if (sel) begin
      case (upd.kind)
        UPD_BUMP: begin
          if (count != COUNT_MAX) begin
            count <= count + 1'b1;
          end
        end
        UPD_FILL: begin
          valid  <= 1'b1;
          key    <= upd.key;
          handle <= upd.handle;
          count  <= COUNT_BITS'(1);
        end
        UPD_CLEAR: begin
          valid  <= 1'b0;
          key    <= '0;
          handle <= '0;
          count  <= '0;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule

// ===== design/lrkc_chain.sv =====
// Row of SLOTS cells; the search token enters at cell 0, is registered in each
// cell and leaves the last one. Depends on lrkc_pkg and lrkc_cell.
`timescale 1ns / 1ps

module lrkc_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lrkc_pkg::KEY_W-1:0] req_key,
  input  logic                       start,
  output logic                       done,
  output lrkc_pkg::scan_t            result,
  input  lrkc_pkg::upd_t             upd
);
  import lrkc_pkg::*;

  scan_t tok   [SLOTS+1];
  logic  tok_v [SLOTS+1];

  // Seed token: nothing found, victim defaults to slot 0
  always_comb begin
    tok[0].found       = 1'b0;
    tok[0].hit_idx     = '0;
    tok[0].hit_handle  = '0;
    tok[0].least_count = COUNT_MAX;
    tok[0].min_idx     = '0;
    tok_v[0]           = start;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lrkc_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cell_idx       (IDX_W'(g)),
      .req_key        (req_key),
      .scan_in_valid  (tok_v[g]),
      .scan_in        (tok[g]),
      .scan_out_valid (tok_v[g+1]),
      .scan_out       (tok[g+1]),
      .upd            (upd)
    );
  end

  assign done   = tok_v[SLOTS];
  assign result = tok[SLOTS];

endmodule

// ===== design/lfu_recent_key_cache_top.sv =====
// Top level of the LFU recent-key cache: request capture, controller,
// update decision and result register. Depends on lrkc_pkg and lrkc_chain.
`timescale 1ns / 1ps

// Fully associative cache of SLOTS (16) slots with least-frequently-used
// replacement. Items enter on in_valid/in_ready carrying operation, key and
// handle_in; each produces exactly one result (hit, handle_out) on
// out_valid/out_ready.
// One item is processed at a time. After acceptance a search token walks the
// row of slot cells, one cell per cycle, collecting the first matching slot
// and the slot with the smallest use count; an update step then applies the
// bump, fill or clear and loads the result register. The next item is
// accepted only once that update step has committed and the controller is
// back in idle.
// The result register holds until taken; while the receiver stalls with a
// result still pending, a finished scan waits in its update step and no new
// item is accepted. Synchronous reset empties every slot (valid, key, handle
// and count cleared at once), drops any item in flight and clears out_valid.

module lfu_recent_key_cache_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [lrkc_pkg::KEY_W-1:0]    key,
  input  logic [lrkc_pkg::HANDLE_W-1:0] handle_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [lrkc_pkg::HANDLE_W-1:0] handle_out
);
  import lrkc_pkg::*;

  ctrl_state_t state, state_next;

  logic [1:0]          req_op;
  logic [KEY_W-1:0]    req_key;
  logic [HANDLE_W-1:0] req_handle;
  logic                scan_start;

  logic  chain_done;
  scan_t last;
  upd_t  upd;

  logic                in_fire;
  logic                commit;
  logic                res_hit;
  logic [HANDLE_W-1:0] res_handle;

  assign in_fire = in_valid && in_ready;
  assign commit  = (state == ST_UPDATE) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_SCAN;
      ST_SCAN:   if (chain_done) state_next = ST_UPDATE;
      ST_UPDATE: if (commit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   in_ready = 1'b0;
      ST_UPDATE: in_ready = 1'b0;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_start <= 1'b0;
    end else begin
      state      <= state_next;
      scan_start <= in_fire;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op     <= operation;
      req_key    <= key;
      req_handle <= handle_in;
    end
  end

  lrkc_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .req_key (req_key),
    .start   (scan_start),
    .done    (chain_done),
    .result  (last),
    .upd     (upd)
  );

  // Decide the slot update and the result from the finished token
  always_comb begin
    upd.en     = 1'b0;
    upd.kind   = UPD_BUMP;
    upd.idx    = last.hit_idx;
    upd.key    = req_key;
    upd.handle = req_handle;
    res_hit    = 1'b0;
    res_handle = '0;
    unique case (req_op)
      OP_LOOKUP: begin
        if (last.found) begin
          upd.en     = commit;
          res_hit    = 1'b1;
          res_handle = last.hit_handle;
        end
      end
      OP_INSERT: begin
        if (req_handle != '0) begin
          upd.en = commit;
          if (last.found) begin
            res_hit    = 1'b1;
            res_handle = last.hit_handle;
          end else begin
            upd.kind   = UPD_FILL;
            upd.idx    = last.min_idx;
            res_handle = req_handle;
          end
        end
      end
      OP_REMOVE: begin
        if (last.found) begin
          upd.en     = commit;
          upd.kind   = UPD_CLEAR;
          res_hit    = 1'b1;
          res_handle = last.hit_handle;
        end
      end
      default: begin
        upd.en = 1'b0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (commit) begin
      hit        <= res_hit;
      handle_out <= res_handle;
    end
  end

  // The token only comes out of the chain while the controller scans
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain_done |-> (state == ST_SCAN))
    else $error("scan token left the chain outside a scan");

  // Only one token in flight at a time
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    chain_done |=> !chain_done)
    else $error("back-to-back scan tokens");

  // A fill never replaces a slot when the key was already present
  a_fill_on_miss: assert property (@(posedge clk) disable iff (rst)
    (upd.en && (upd.kind == UPD_FILL)) |-> !last.found)
    else $error("fill issued on a hit");

  // A new result appears only after an update step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_UPDATE))
    else $error("result without an update step");

endmodule
